FILE: src/saf_pkg.sv
// shared constants for the selectable average filter
package saf_pkg;

  // field and register widths
  localparam int SAMPLE_W = 16;
  localparam int MODE_W   = 2;
  localparam int LEN_W    = 5;
  localparam int CFG_W    = 5;
  localparam int IDX_W    = 1;

  // default window depth and queue depth
  localparam int WINDOW_MAX_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  // shortest block the trimmed mean works on
  localparam int TRIM_MIN_LEN = 3;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [IDX_W-1:0] CFG_LEN  = 1'b1;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_SLIDE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLOCK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRIMMED  = 2'd3;

  // block min/max start values
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'sh8000;

endpackage

FILE: src/selectable_average_filter.sv
// top level of the selectable average filter
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   in_sample (16 bit signed)
//   out      source     out_valid / out_stall out_average (16 bit signed)
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// the front takes a sample while idle and the job queue has room, then updates
// its sums first; each result goes through a bit-serial divider that takes no
// new job until its last result is loaded, so the sliding mean runs at its pace
// synchronous active-low reset; a config write clears sums, count and min/max
// a stalled output holds the divider's next result, then fills the queue
module selectable_average_filter #(
  parameter int WINDOW_MAX = saf_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [saf_pkg::IDX_W-1:0]           cfg_index,
  input  logic [saf_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [saf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [saf_pkg::SAMPLE_W-1:0] out_average
);

  localparam int TRI_MAX = WINDOW_MAX * (WINDOW_MAX + 1) / 2;
  localparam int DSW     = $clog2(TRI_MAX + 1);
  localparam int WW      = saf_pkg::SAMPLE_W + DSW;
  localparam int QW      = WW + DSW;

  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  logic signed [WW-1:0] push_dividend;
  logic [DSW-1:0]       push_divisor;
  logic [QW-1:0]        pop_data;

  saf_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .WW         (WW),
    .DSW        (DSW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_dividend (push_dividend),
    .q_divisor  (push_divisor)
  );

  // division jobs waiting for the back end
  saf_fifo #(
    .WIDTH (QW),
    .DEPTH (saf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_dividend, push_divisor}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  saf_div #(
    .WW  (WW),
    .DSW (DSW)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_dividend  (pop_data[QW-1:DSW]),
    .q_divisor   (pop_data[DSW-1:0]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average)
  );

endmodule

FILE: src/saf_ram.sv
// generic single write port ram with registered read
module saf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/saf_fifo.sv
// short queue of division jobs between front and back
module saf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/saf_front.sv
// front: configuration, sample accept, running sums and division job issue
module saf_front #(
  parameter int WINDOW_MAX = saf_pkg::WINDOW_MAX_DEF,
  parameter int WW         = 24,
  parameter int DSW        = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [saf_pkg::IDX_W-1:0]           cfg_index,
  input  logic [saf_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [saf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                q_full,
  output logic                                q_push,
  output logic signed [WW-1:0]                q_dividend,
  output logic [DSW-1:0]                      q_divisor
);

  localparam int SW  = saf_pkg::SAMPLE_W;
  localparam int LW  = $clog2(WINDOW_MAX + 1);
  localparam int AW  = $clog2(WINDOW_MAX);
  localparam int RW  = SW + LW;
  localparam int PW  = SW + LW + 1;
  localparam int TW  = 2 * LW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                            state_r, state_nxt;
  logic [saf_pkg::MODE_W-1:0]      mode_r;
  logic [saf_pkg::LEN_W-1:0]       len_r;
  logic signed [SW-1:0]            samp_r;
  logic signed [PW-1:0]            prod_r;
  logic signed [RW-1:0]            rsum_r, rsum_nxt;
  logic signed [WW-1:0]            wsum_r, wsum_nxt;
  logic [LW-1:0]                   fill_r, fill_nxt;
  logic signed [SW-1:0]            min_r, min_nxt;
  logic signed [SW-1:0]            max_r, max_nxt;
  logic [AW-1:0]                   ptr_r, ptr_nxt;

  logic                            accept;
  logic [LW-1:0]                   n_eff;
  logic [LW-1:0]                   fill_inc;
  logic [LW:0]                     old_pos;
  logic [AW-1:0]                   old_addr;
  logic signed [SW-1:0]            old_samp;
  logic                            ram_we;
  logic [TW-1:0]                   n_wide;
  logic [TW-1:0]                   tri_full;
  logic                            emit;
  logic signed [WW-1:0]            dividend;
  logic [DSW-1:0]                  divisor;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || q_full;

  // effective window length: zero acts as one, oversize as the maximum
  always_comb begin
    if (len_r == '0) begin
      n_eff = LW'(1);
    end else if (32'(len_r) > WINDOW_MAX) begin
      n_eff = LW'(WINDOW_MAX);
    end else begin
      n_eff = LW'(len_r);
    end
  end

  assign fill_inc = fill_r + 1'b1;

  // triangular divisor n(n+1)/2 for the weighted mean
  assign n_wide   = TW'(n_eff);
  assign tri_full = n_wide * (n_wide + 1'b1);

  // address of the sample that leaves the sliding window
  always_comb begin
    old_pos = (LW + 1)'(ptr_r);
    if (old_pos >= (LW + 1)'(n_eff)) begin
      old_addr = AW'(old_pos - (LW + 1)'(n_eff));
    end else begin
      old_addr = AW'(old_pos + (LW + 1)'(WINDOW_MAX) - (LW + 1)'(n_eff));
    end
  end

  assign ram_we = (state_r == ST_UPD) && (mode_r == saf_pkg::MODE_SLIDE);

  saf_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_MAX)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (samp_r),
    .raddr (old_addr),
    .rdata (old_samp)
  );

  // sum, count and min/max update for the held sample
  always_comb begin
    state_nxt = state_r;
    rsum_nxt  = rsum_r;
    wsum_nxt  = wsum_r;
    fill_nxt  = fill_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ptr_nxt   = ptr_r;
    emit      = 1'b0;
    dividend  = '0;
    divisor   = DSW'(n_eff);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
        if (mode_r == saf_pkg::MODE_SLIDE) begin
          if (fill_r >= n_eff) begin
            rsum_nxt = rsum_r - RW'(old_samp) + RW'(samp_r);
          end else begin
            rsum_nxt = rsum_r + RW'(samp_r);
            fill_nxt = fill_inc;
          end
          ptr_nxt  = (ptr_r == AW'(WINDOW_MAX - 1)) ? '0 : ptr_r + 1'b1;
          emit     = (fill_nxt == n_eff);
          dividend = WW'(rsum_nxt);
        end else if (!(mode_r == saf_pkg::MODE_TRIMMED &&
                       32'(n_eff) < saf_pkg::TRIM_MIN_LEN)) begin
          rsum_nxt = rsum_r + RW'(samp_r);
          wsum_nxt = wsum_r + WW'(prod_r);
          min_nxt  = (samp_r < min_r) ? samp_r : min_r;
          max_nxt  = (samp_r > max_r) ? samp_r : max_r;
          fill_nxt = fill_inc;
          unique case (mode_r)
            saf_pkg::MODE_WEIGHTED: begin
              dividend = wsum_nxt;
              divisor  = DSW'(tri_full >> 1);
            end
            saf_pkg::MODE_TRIMMED: begin
              dividend = WW'(rsum_nxt) - WW'(min_nxt) - WW'(max_nxt);
              divisor  = DSW'(n_eff - LW'(2));
            end
            default: begin
              dividend = WW'(rsum_nxt);
              divisor  = DSW'(n_eff);
            end
          endcase
          if (fill_inc == n_eff) begin
            emit     = 1'b1;
            rsum_nxt = '0;
            wsum_nxt = '0;
            fill_nxt = '0;
            min_nxt  = saf_pkg::SAMPLE_POS_MAX;
            max_nxt  = saf_pkg::SAMPLE_NEG_MAX;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign q_push     = emit;
  assign q_dividend = dividend;
  assign q_divisor  = divisor;

  // control state, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= saf_pkg::MODE_SLIDE;
      len_r   <= saf_pkg::LEN_W'(1);
      rsum_r  <= '0;
      wsum_r  <= '0;
      fill_r  <= '0;
      min_r   <= saf_pkg::SAMPLE_POS_MAX;
      max_r   <= saf_pkg::SAMPLE_NEG_MAX;
      ptr_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        saf_pkg::CFG_MODE: mode_r <= cfg_data[saf_pkg::MODE_W-1:0];
        saf_pkg::CFG_LEN:  len_r  <= cfg_data[saf_pkg::LEN_W-1:0];
        default:           mode_r <= mode_r;
      endcase
      state_r <= ST_IDLE;
      rsum_r  <= '0;
      wsum_r  <= '0;
      fill_r  <= '0;
      min_r   <= saf_pkg::SAMPLE_POS_MAX;
      max_r   <= saf_pkg::SAMPLE_NEG_MAX;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rsum_r  <= rsum_nxt;
      wsum_r  <= wsum_nxt;
      fill_r  <= fill_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // held sample and its block weight product
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r <= in_sample;
      prod_r <= $signed(in_sample) * $signed({1'b0, fill_inc});
    end
  end

endmodule

FILE: src/saf_div.sv
// back: bit-serial signed divider with output register
module saf_div #(
  parameter int WW  = 24,
  parameter int DSW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic signed [WW-1:0]                q_dividend,
  input  logic [DSW-1:0]                      q_divisor,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [saf_pkg::SAMPLE_W-1:0] out_average
);

  localparam int CW = $clog2(WW + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]                        bstate_r, bstate_nxt;
  logic [WW-1:0]                     quo_r, quo_nxt;
  logic [DSW-1:0]                    rem_r, rem_nxt;
  logic [DSW-1:0]                    dsr_r;
  logic                              neg_r;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic                              out_valid_r;
  logic signed [saf_pkg::SAMPLE_W-1:0] out_average_r;

  logic [DSW:0]                      rem_sh;
  logic [DSW:0]                      rem_diff;
  logic                              out_free;
  logic                              load_out;
  logic [WW-1:0]                     quo_signed;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (bstate_r == B_IDLE) && !q_empty;
  assign load_out = (bstate_r == B_DONE) && out_free;

  // one restoring step per cycle
  assign rem_sh   = {rem_r, quo_r[WW-1]};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_comb begin
    bstate_nxt = bstate_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    unique case (bstate_r)
      B_IDLE: begin
        if (q_pop) begin
          bstate_nxt = B_RUN;
          quo_nxt    = q_dividend[WW-1] ? WW'(-q_dividend) : WW'(q_dividend);
          rem_nxt    = '0;
          cnt_nxt    = CW'(WW);
        end
      end
      B_RUN: begin
        if (!rem_diff[DSW]) begin
          rem_nxt = rem_diff[DSW-1:0];
          quo_nxt = {quo_r[WW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DSW-1:0];
          quo_nxt = {quo_r[WW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          bstate_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          bstate_nxt = B_IDLE;
        end
      end
      default: begin
        bstate_nxt = B_IDLE;
      end
    endcase
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  // control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      cnt_r    <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // divider datapath and result register
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (q_pop) begin
      dsr_r <= q_divisor;
      neg_r <= q_dividend[WW-1];
    end
    if (load_out) begin
      out_average_r <= quo_signed[saf_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

endmodule

FILE: bench/selectable_average_filter_tb.sv
// self-checking testbench for selectable_average_filter with a built-in predictor
`timescale 1ns / 100ps

module selectable_average_filter_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS  = 1800;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [saf_pkg::IDX_W-1:0]           cfg_index = saf_pkg::CFG_MODE;
  logic [saf_pkg::CFG_W-1:0]           cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [saf_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [saf_pkg::SAMPLE_W-1:0] out_average;

  selectable_average_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_average(out_average)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // samples waiting to be sent and averages waiting to come back
  logic signed [saf_pkg::SAMPLE_W-1:0] pending_samples [$];
  logic signed [saf_pkg::SAMPLE_W-1:0] expected_avgs [$];

  // filter state as the block should hold it
  logic [saf_pkg::MODE_W-1:0]          mode_reg = saf_pkg::MODE_SLIDE;
  logic [saf_pkg::LEN_W-1:0]           len_reg = 5'd1;
  logic signed [saf_pkg::SAMPLE_W-1:0] history [saf_pkg::WINDOW_MAX_DEF];
  longint                              sum_acc;
  longint                              wsum_acc;
  int                                  fill_cnt;
  int                                  blk_min;
  int                                  blk_max;

  int  err_cnt = 0;
  int  samples_sent = 0;
  int  averages_seen = 0;
  int  setting_cnt = 0;
  int  cycle_cnt = 0;
  bit  gaps_on = 1'b1;
  bit  in_xfer = 1'b0;
  int  in_gap = 0;
  int  out_hold = 0;
  logic signed [saf_pkg::SAMPLE_W-1:0] want_avg;

  function automatic void clear_filter();
    foreach (history[i]) history[i] = '0;
    sum_acc  = 0;
    wsum_acc = 0;
    fill_cnt = 0;
    blk_min  = saf_pkg::SAMPLE_POS_MAX;
    blk_max  = saf_pkg::SAMPLE_NEG_MAX;
  endfunction

  // expected average, if any, for one accepted sample
  function automatic void predict_average(input logic signed [saf_pkg::SAMPLE_W-1:0] s);
    int     n;
    longint res;
    if (len_reg == 0) n = 1;
    else if (len_reg > saf_pkg::WINDOW_MAX_DEF) n = saf_pkg::WINDOW_MAX_DEF;
    else n = int'(len_reg);
    if (mode_reg == saf_pkg::MODE_SLIDE) begin
      if (fill_cnt >= n) sum_acc -= history[n-1];
      for (int i = saf_pkg::WINDOW_MAX_DEF - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s;
      sum_acc += s;
      if (fill_cnt < n) fill_cnt++;
      if (fill_cnt < n) return;
      res = sum_acc / longint'(n);
    end else begin
      // trimmed mean on a block shorter than three ignores the sample
      if (mode_reg == saf_pkg::MODE_TRIMMED && n < saf_pkg::TRIM_MIN_LEN) return;
      sum_acc  += s;
      wsum_acc += longint'(s) * longint'(fill_cnt + 1);
      if (s < blk_min) blk_min = s;
      if (s > blk_max) blk_max = s;
      fill_cnt++;
      if (fill_cnt < n) return;
      case (mode_reg)
        saf_pkg::MODE_BLOCK:    res = sum_acc / longint'(n);
        saf_pkg::MODE_WEIGHTED: res = wsum_acc / longint'(n * (n + 1) / 2);
        default:                res = (sum_acc - blk_min - blk_max) / longint'(n - 2);
      endcase
      sum_acc  = 0;
      wsum_acc = 0;
      fill_cnt = 0;
      blk_min  = saf_pkg::SAMPLE_POS_MAX;
      blk_max  = saf_pkg::SAMPLE_NEG_MAX;
    end
    expected_avgs.push_back(res[saf_pkg::SAMPLE_W-1:0]);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [saf_pkg::SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return saf_pkg::SAMPLE_POS_MAX;
        1:       return saf_pkg::SAMPLE_NEG_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 30) return saf_pkg::SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
    return saf_pkg::SAMPLE_W'($urandom);
  endfunction

  // window length: mostly in range, sometimes zero or beyond the maximum
  function automatic logic [saf_pkg::LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 14) return saf_pkg::LEN_W'($urandom_range(saf_pkg::WINDOW_MAX_DEF + 1, 31));
    if (r < 45) return saf_pkg::LEN_W'($urandom_range(1, 3));
    return saf_pkg::LEN_W'($urandom_range(4, saf_pkg::WINDOW_MAX_DEF));
  endfunction

  task automatic write_reg(input logic [saf_pkg::IDX_W-1:0] idx,
                           input logic [saf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == saf_pkg::CFG_MODE) mode_reg = val[saf_pkg::MODE_W-1:0];
    else len_reg = val[saf_pkg::LEN_W-1:0];
    clear_filter();
  endtask

  task automatic set_filter(input logic [saf_pkg::MODE_W-1:0] m,
                            input logic [saf_pkg::LEN_W-1:0] l);
    write_reg(saf_pkg::CFG_MODE, saf_pkg::CFG_W'(m));
    write_reg(saf_pkg::CFG_LEN, saf_pkg::CFG_W'(l));
    setting_cnt++;
  endtask

  // wait for every sample to be sent and every average to arrive, then settle
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_avgs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push3(input logic signed [saf_pkg::SAMPLE_W-1:0] a, b, c);
    pending_samples.push_back(a);
    pending_samples.push_back(b);
    pending_samples.push_back(c);
  endtask

  // sample transfers feed the predictor, average transfers are checked
  always @(posedge clk) begin
    in_xfer = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      averages_seen++;
      if (expected_avgs.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected average, expected none, actual %0d", $time, out_average);
      end else begin
        want_avg = expected_avgs.pop_front();
        if (out_average !== want_avg) begin
          err_cnt++;
          $display("%0t: average expected %0d, actual %0d", $time, want_avg, out_average);
        end
      end
    end
    if (in_xfer) begin
      samples_sent++;
      predict_average(in_sample);
    end
  end

  // driver: next sample after a transfer or while idle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_xfer)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_sample <= pending_samples.pop_front();
        in_valid  <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stalls in bursts
  always @(negedge clk) begin
    if (out_hold == 0 && $urandom_range(0, 3) == 0) out_hold = pick_gap();
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("selectable_average_filter: mismatch");
      $finish;
    end
  end

  initial begin
    int random_cnt;
    int items;
    int n_eff;
    logic [saf_pkg::MODE_W-1:0] m;
    logic [saf_pkg::LEN_W-1:0]  l;

    random_cnt = 0;
    clear_filter();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // reset setting: sliding mean over one sample, field extremes
    pending_samples.push_back(saf_pkg::SAMPLE_POS_MAX);
    pending_samples.push_back(saf_pkg::SAMPLE_NEG_MAX);
    pending_samples.push_back('0);
    pending_samples.push_back('1);
    drain();

    // zero window length behaves as one
    set_filter(saf_pkg::MODE_BLOCK, 5'd0);
    pending_samples.push_back(16'sd1);
    pending_samples.push_back(-16'sd1);
    drain();

    // trimmed mean with a block too short: samples are ignored
    set_filter(saf_pkg::MODE_TRIMMED, 5'd2);
    push3(saf_pkg::SAMPLE_POS_MAX, saf_pkg::SAMPLE_NEG_MAX, 16'sd5);
    drain();

    // trimmed mean dropping both extremes
    set_filter(saf_pkg::MODE_TRIMMED, 5'd3);
    push3(saf_pkg::SAMPLE_NEG_MAX, saf_pkg::SAMPLE_POS_MAX, 16'sd0);
    drain();

    set_filter(saf_pkg::MODE_WEIGHTED, 5'd3);
    push3(saf_pkg::SAMPLE_POS_MAX, saf_pkg::SAMPLE_POS_MAX, saf_pkg::SAMPLE_POS_MAX);
    drain();

    // negative sums truncate toward zero
    set_filter(saf_pkg::MODE_SLIDE, 5'd2);
    push3(saf_pkg::SAMPLE_NEG_MAX, saf_pkg::SAMPLE_NEG_MAX, saf_pkg::SAMPLE_POS_MAX);
    drain();

    set_filter(saf_pkg::MODE_BLOCK, 5'd3);
    push3(-16'sd1, -16'sd1, 16'sd0);
    drain();

    // random settings, the second through seventh pinned to the extremes
    while (random_cnt < RANDOM_ITEMS) begin
      case (setting_cnt)
        7:  begin m = saf_pkg::MODE_SLIDE;    l = 5'd16; end
        8:  begin m = saf_pkg::MODE_WEIGHTED; l = 5'd16; end
        9:  begin m = saf_pkg::MODE_TRIMMED;  l = 5'd16; end
        10: begin m = saf_pkg::MODE_BLOCK;    l = 5'd31; end
        11: begin m = saf_pkg::MODE_TRIMMED;  l = 5'd17; end
        12: begin m = saf_pkg::MODE_WEIGHTED; l = 5'd0;  end
        default: begin
          m = saf_pkg::MODE_W'($urandom_range(0, 3));
          l = pick_len();
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      set_filter(m, l);
      if (l == 0) n_eff = 1;
      else if (l > saf_pkg::WINDOW_MAX_DEF) n_eff = saf_pkg::WINDOW_MAX_DEF;
      else n_eff = int'(l);
      if (m == saf_pkg::MODE_TRIMMED && n_eff < saf_pkg::TRIM_MIN_LEN) items = 6;
      else if (n_eff <= 3) items = $urandom_range(20, 80);
      else items = $urandom_range(40, 150);
      repeat (items) pending_samples.push_back(rand_sample());
      if (!(m == saf_pkg::MODE_TRIMMED && n_eff < saf_pkg::TRIM_MIN_LEN)) random_cnt += items;
      drain();
    end

    $display("%0d samples sent under %0d filter settings, all four modes",
             samples_sent, setting_cnt);
    $display("window lengths in and out of range, %0d averages checked, %0d errors",
             averages_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("selectable_average_filter: match");
    end else begin
      $display("selectable_average_filter: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/saf_pkg.sv
src/saf_ram.sv
src/saf_fifo.sv
src/saf_front.sv
src/saf_div.sv
src/selectable_average_filter.sv
bench/selectable_average_filter_tb.sv
